FILE: rtl/core/fixed_point_motion_integrator_macros.svh
// Assertion macros for the motion integrator checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef FIXED_POINT_MOTION_INTEGRATOR_MACROS_SVH
`define FIXED_POINT_MOTION_INTEGRATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FPMI_ASSERT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FPMI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/fpmi_pkg.sv
// Types, constants and saturating fixed-point helpers for the motion integrator.
// No dependencies; imported by every module of the block.
package fpmi_pkg;

  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned RES_W     = 9;
  localparam int unsigned PROD_W    = DATA_W + RES_W;
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned WHOLE_W   = DATA_W - FRAC_BITS;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 168;

  localparam logic [RES_W-1:0]  Q8_ONE  = 9'd256;
  localparam logic [DATA_W-1:0] INT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;
  localparam logic [PIX_W-1:0]  PIX_MAX = 16'h7FFF;
  localparam logic [PIX_W-1:0]  PIX_MIN = 16'h8000;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_POS = 3'd0,
    CMD_SET_VEL = 3'd1,
    CMD_INTEG   = 3'd2,
    CMD_CLAMP   = 3'd3,
    CMD_BRAKE   = 3'd4,
    CMD_BOUNCE  = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_SET_POS,
    OP_SET_VEL,
    OP_INTEG,
    OP_CLAMP,
    OP_BRAKE,
    OP_BOUNCE
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X       = 3'd0,
    REG_MAX_X       = 3'd1,
    REG_MIN_Y       = 3'd2,
    REG_MAX_Y       = 3'd3,
    REG_RESTITUTION = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [DATA_W-1:0] min_x;
    logic [DATA_W-1:0] max_x;
    logic [DATA_W-1:0] min_y;
    logic [DATA_W-1:0] max_y;
    logic [RES_W-1:0]  restitution;
  } cfg_t;

  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] arg_x;
    logic [DATA_W-1:0] arg_y;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] pos_x;
    logic [DATA_W-1:0] pos_y;
    logic [DATA_W-1:0] vel_x;
    logic [DATA_W-1:0] vel_y;
    logic              changed;
    logic [3:0]        hit_mask;
  } result_t;

  typedef struct packed {
    logic [DATA_W-1:0] pos;
    logic [DATA_W-1:0] vel;
    logic              hit_lo;
    logic              hit_hi;
  } axis_t;

  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      sat_add = s[DATA_W] ? INT_MIN : INT_MAX;
    end else begin
      sat_add = s[DATA_W-1:0];
    end
  endfunction

  // m is known non-negative
  function automatic logic [DATA_W-1:0] limit_sym(input logic [DATA_W-1:0] v,
                                                  input logic [DATA_W-1:0] m);
    logic [DATA_W-1:0] neg_m;
    neg_m = ~m + 1'b1;
    if ($signed(v) > $signed(m)) begin
      limit_sym = m;
    end else if ($signed(v) < $signed(neg_m)) begin
      limit_sym = neg_m;
    end else begin
      limit_sym = v;
    end
  endfunction

  // amt is known non-negative, so neither add can overflow
  function automatic logic [DATA_W-1:0] toward_zero(input logic [DATA_W-1:0] v,
                                                    input logic [DATA_W-1:0] amt);
    logic [DATA_W-1:0] n;
    n = '0;
    toward_zero = v;
    if (v[DATA_W-1]) begin
      n = v + amt;
      toward_zero = n[DATA_W-1] ? n : '0;
    end else if (v != '0) begin
      n = v - amt;
      toward_zero = (n[DATA_W-1] || n == '0) ? '0 : n;
    end
  endfunction

  // -(v * r / 2^FRAC_BITS) with truncated magnitude, saturated to INT_MAX
  function automatic logic [DATA_W-1:0] reverse_scaled(input logic [DATA_W-1:0] v,
                                                       input logic [RES_W-1:0]  r);
    logic [DATA_W-1:0]          mag;
    logic [PROD_W-1:0]          prod;
    logic [PROD_W-FRAC_BITS-1:0] s;
    logic [DATA_W-1:0]          sm;
    mag  = v[DATA_W-1] ? (~v + 1'b1) : v;
    prod = PROD_W'(mag) * PROD_W'(r);
    s    = prod[PROD_W-1:FRAC_BITS];
    sm   = (s > (PROD_W-FRAC_BITS)'(INT_MAX)) ? INT_MAX : s[DATA_W-1:0];
    reverse_scaled = v[DATA_W-1] ? sm : (~sm + 1'b1);
  endfunction

  function automatic axis_t bounce_axis(input logic [DATA_W-1:0] pos,
                                        input logic [DATA_W-1:0] vel,
                                        input logic [DATA_W-1:0] lo,
                                        input logic [DATA_W-1:0] hi,
                                        input logic [RES_W-1:0]  r);
    axis_t a;
    a.pos    = pos;
    a.vel    = vel;
    a.hit_lo = $signed(pos) < $signed(lo);
    a.hit_hi = !a.hit_lo && ($signed(pos) > $signed(hi));
    if (a.hit_lo) begin
      a.pos = lo;
    end else if (a.hit_hi) begin
      a.pos = hi;
    end
    if ((a.hit_lo && vel[DATA_W-1]) || (a.hit_hi && !vel[DATA_W-1] && vel != '0)) begin
      a.vel = reverse_scaled(vel, r);
    end
    return a;
  endfunction

  function automatic logic [PIX_W-1:0] to_pixel(input logic [DATA_W-1:0] v);
    logic [WHOLE_W-1:0] w;
    w = v[DATA_W-1:FRAC_BITS];
    if (w[WHOLE_W-1] && !(&w[WHOLE_W-1:PIX_W-1])) begin
      to_pixel = PIX_MIN;
    end else if (!w[WHOLE_W-1] && (|w[WHOLE_W-1:PIX_W-1])) begin
      to_pixel = PIX_MAX;
    end else begin
      to_pixel = w[PIX_W-1:0];
    end
  endfunction

endpackage

FILE: rtl/core/fpmi_queue.sv
// Small request queue between the decode front and the execute back.
// Depends on fpmi_pkg for the request type.
module fpmi_queue import fpmi_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  item_t wr_item_i,
  output logic  rd_valid_o,
  input  logic  rd_pop_i,
  output item_t rd_item_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t             mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              push, pop;

  assign wr_ready_o = (count_q != CNT_W'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_pop_i && rd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

FILE: rtl/core/fpmi_front.sv
// Input side: accepts requests, decodes cmd into an operation and queues it.
// Depends on fpmi_pkg and fpmi_queue.
module fpmi_front import fpmi_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [IN_DATA_W-1:0] s_axis_tdata_i,
  input  logic [CMD_W-1:0]     s_axis_tuser_i,
  output logic                 q_valid_o,
  input  logic                 q_pop_i,
  output item_t                q_item_o
);

  item_t item;
  logic  arg_neg;
  logic  bounce_ok;

  assign arg_neg   = s_axis_tdata_i[DATA_W-1] || s_axis_tdata_i[2*DATA_W-1];
  assign bounce_ok = ($signed(cfg_i.min_x) <= $signed(cfg_i.max_x)) &&
                     ($signed(cfg_i.min_y) <= $signed(cfg_i.max_y)) &&
                     (cfg_i.restitution <= Q8_ONE);

  always_comb begin
    item.arg_x = s_axis_tdata_i[DATA_W-1:0];
    item.arg_y = s_axis_tdata_i[2*DATA_W-1:DATA_W];
    case (s_axis_tuser_i)
      CMD_SET_POS: item.op = OP_SET_POS;
      CMD_SET_VEL: item.op = OP_SET_VEL;
      CMD_INTEG:   item.op = OP_INTEG;
      CMD_CLAMP:   item.op = arg_neg ? OP_NOP : OP_CLAMP;
      CMD_BRAKE:   item.op = arg_neg ? OP_NOP : OP_BRAKE;
      CMD_BOUNCE:  item.op = bounce_ok ? OP_BOUNCE : OP_NOP;
      default:     item.op = OP_NOP;
    endcase
  end

  fpmi_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (s_axis_tvalid_i),
    .wr_ready_o (s_axis_tready_o),
    .wr_item_i  (item),
    .rd_valid_o (q_valid_o),
    .rd_pop_i   (q_pop_i),
    .rd_item_o  (q_item_o)
  );

endmodule

FILE: rtl/core/fpmi_back.sv
// Execute side: holds position and velocity, applies one request per cycle
// while the output register can load, and registers the result. Depends on fpmi_pkg.
module fpmi_back import fpmi_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  q_valid_i,
  output logic                  q_pop_o,
  input  item_t                 q_item_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic [DATA_W-1:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;
  result_t           res_d, res_q;
  logic              out_valid_q;
  logic              load;
  logic [DATA_W-1:0] nvx, nvy;
  axis_t             bx, by;

  assign load    = !out_valid_q || m_axis_tready_i;
  assign q_pop_o = q_valid_i && load;

  assign bx = bounce_axis(pos_x_q, vel_x_q, cfg_i.min_x, cfg_i.max_x, cfg_i.restitution);
  assign by = bounce_axis(pos_y_q, vel_y_q, cfg_i.min_y, cfg_i.max_y, cfg_i.restitution);

  always_comb begin
    res_d.pos_x    = pos_x_q;
    res_d.pos_y    = pos_y_q;
    res_d.vel_x    = vel_x_q;
    res_d.vel_y    = vel_y_q;
    res_d.changed  = 1'b0;
    res_d.hit_mask = '0;
    nvx            = '0;
    nvy            = '0;
    case (q_item_i.op)
      OP_SET_POS: begin
        res_d.pos_x = q_item_i.arg_x;
        res_d.pos_y = q_item_i.arg_y;
      end
      OP_SET_VEL: begin
        res_d.vel_x = q_item_i.arg_x;
        res_d.vel_y = q_item_i.arg_y;
      end
      OP_INTEG: begin
        nvx         = sat_add(vel_x_q, q_item_i.arg_x);
        nvy         = sat_add(vel_y_q, q_item_i.arg_y);
        res_d.vel_x = nvx;
        res_d.vel_y = nvy;
        res_d.pos_x = sat_add(pos_x_q, nvx);
        res_d.pos_y = sat_add(pos_y_q, nvy);
      end
      OP_CLAMP: begin
        nvx           = limit_sym(vel_x_q, q_item_i.arg_x);
        nvy           = limit_sym(vel_y_q, q_item_i.arg_y);
        res_d.vel_x   = nvx;
        res_d.vel_y   = nvy;
        res_d.changed = (nvx != vel_x_q) || (nvy != vel_y_q);
      end
      OP_BRAKE: begin
        nvx           = toward_zero(vel_x_q, q_item_i.arg_x);
        nvy           = toward_zero(vel_y_q, q_item_i.arg_y);
        res_d.vel_x   = nvx;
        res_d.vel_y   = nvy;
        res_d.changed = (nvx != vel_x_q) || (nvy != vel_y_q);
      end
      OP_BOUNCE: begin
        res_d.pos_x    = bx.pos;
        res_d.vel_x    = bx.vel;
        res_d.pos_y    = by.pos;
        res_d.vel_y    = by.vel;
        res_d.hit_mask = {by.hit_hi, by.hit_lo, bx.hit_hi, bx.hit_lo};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        pos_x_q <= res_d.pos_x;
        pos_y_q <= res_d.pos_y;
        vel_x_q <= res_d.vel_x;
        vel_y_q <= res_d.vel_y;
      end
      if (load) begin
        out_valid_q <= q_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000,
                            to_pixel(res_q.pos_y), to_pixel(res_q.pos_x),
                            res_q.hit_mask, res_q.changed,
                            res_q.vel_y, res_q.vel_x, res_q.pos_y, res_q.pos_x};

endmodule

FILE: rtl/core/fixed_point_motion_integrator.sv
// Top level of the 2D saturating fixed-point motion integrator.
// Holds the configuration registers; depends on fpmi_pkg, fpmi_front, fpmi_back.
//
// Usage:
// - s_axis carries one request per handshake: tuser = cmd, tdata = arg_x, arg_y.
// - m_axis returns exactly one result per request, in request order.
// - cfg writes (cfg_index_i, cfg_data_i) are taken every cycle; indexes 0..3
//   are the x/y bounds, 4 the Q8 restitution, other indexes are ignored.
//   Write configuration only while no request is in flight.
// - Path: an accepted request is written into the queue, then executed into
//   the output register, which drives m_axis.
// - Throughput: one request per cycle while m_axis is not stalled. The limit is
//   the combinational state update loop in the execute stage (integrate's two
//   dependent saturating adds, or bounce's 32x9 multiply).
// - Reset: position and velocity clear to zero, bounds open to the full
//   range, restitution to one, queue and output register empty.
// - Receiver stall: the output register holds its result, up to QUEUE_DEPTH
//   more requests are taken into the queue, then s_axis_tready_o drops.
module fixed_point_motion_integrator import fpmi_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [31:0] arg_x, [63:32] arg_y
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // [2:0] cmd
  input  logic [CMD_W-1:0]      s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [31:0] out_pos_x, [63:32] out_pos_y, [95:64] out_vel_x, [127:96] out_vel_y,
  // [128] changed, [132:129] hit_mask, [148:133] pixel_x, [164:149] pixel_y
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [DATA_W-1:0]     cfg_data_i
);

  cfg_t  cfg_q;
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_x       <= INT_MIN;
      cfg_q.max_x       <= INT_MAX;
      cfg_q.min_y       <= INT_MIN;
      cfg_q.max_y       <= INT_MAX;
      cfg_q.restitution <= Q8_ONE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MIN_X:       cfg_q.min_x       <= cfg_data_i;
        REG_MAX_X:       cfg_q.max_x       <= cfg_data_i;
        REG_MIN_Y:       cfg_q.min_y       <= cfg_data_i;
        REG_MAX_Y:       cfg_q.max_y       <= cfg_data_i;
        REG_RESTITUTION: cfg_q.restitution <= cfg_data_i[RES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fpmi_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_valid_o       (q_valid),
    .q_pop_i         (q_pop),
    .q_item_o        (q_item)
  );

  fpmi_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_valid_i       (q_valid),
    .q_pop_o         (q_pop),
    .q_item_i        (q_item),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

FILE: rtl/core/fpmi_checker.sv
// Port-level assertions for the motion integrator, bound to the top level.
// Depends on fpmi_pkg and fixed_point_motion_integrator_macros.svh.
`include "fixed_point_motion_integrator_macros.svh"

module fpmi_checker import fpmi_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o
);

  logic                  vld;
  logic                  stall;
  logic [OUT_DATA_W-1:0] res;
  logic                  chg;
  logic [3:0]            hits;
  logic                  flags_ok;
  logic                  pix_ok;

  assign vld      = m_axis_tvalid_o;
  assign stall    = m_axis_tvalid_o && !m_axis_tready_i;
  assign res      = m_axis_tdata_o;
  assign chg      = m_axis_tdata_o[128];
  assign hits     = m_axis_tdata_o[132:129];
  assign flags_ok = !(chg && hits != 4'd0) && !(hits[0] && hits[1]) && !(hits[2] && hits[3]);
  assign pix_ok   = (m_axis_tdata_o[148:133] == to_pixel(m_axis_tdata_o[31:0])) &&
                    (m_axis_tdata_o[164:149] == to_pixel(m_axis_tdata_o[63:32]));

  `FPMI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, stall, vld && $stable(res), "stalled result changed")
  `FPMI_ASSERT(a_flags_excl, clk_i, rst_ni, vld, flags_ok, "inconsistent changed/hit flags")
  `FPMI_ASSERT(a_pixel, clk_i, rst_ni, vld, pix_ok, "pixel does not match position")
  `FPMI_ASSERT(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_o, "config write stalled")

endmodule

bind fixed_point_motion_integrator fpmi_checker u_fpmi_checker (.*);
